/* rtl/prp_pkg.sv */
package prp_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_ROT_X   = 3'd0;
	localparam logic [2:0] REG_ROT_Y   = 3'd1;
	localparam logic [2:0] REG_ROT_Z   = 3'd2;
	localparam logic [2:0] REG_OFF_X   = 3'd3;
	localparam logic [2:0] REG_OFF_D   = 3'd4;
	localparam logic [2:0] REG_OFF_Z   = 3'd5;
	localparam logic [2:0] REG_ZOOM    = 3'd6;
	localparam logic [2:0] REG_CENTER  = 3'd7;

	localparam int CFG_W = 32;
	localparam int IDX_W = 3;
	localparam int PT_W  = 16;
	localparam int OFF_W = 24;

	// rotated coordinate widths
	localparam int R1_W  = 19;
	localparam int R2_W  = 22;
	localparam int R3_W  = 25;
	localparam int POS_W = 26;

	// projection numerator and divider widths
	localparam int PRD_W = 43;
	localparam int NUM_W = PRD_W - 4;
	localparam int DEN_W = POS_W;
	localparam int QB    = 18;
	localparam int CMP_W = DEN_W + QB + 1;

	typedef struct packed {
		logic neg_x;
		logic neg_z;
		logic dz;
	} div_tag_t;

endpackage

/* rtl/prp_rotate.sv */
module prp_rotate (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_vld,
	input  logic signed [prp_pkg::PT_W-1:0]    px,
	input  logic signed [prp_pkg::PT_W-1:0]    py,
	input  logic signed [prp_pkg::PT_W-1:0]    pz,
	input  logic [prp_pkg::CFG_W-1:0]          rot_x,
	input  logic [prp_pkg::CFG_W-1:0]          rot_y,
	input  logic [prp_pkg::CFG_W-1:0]          rot_z,
	output logic                               out_vld,
	output logic signed [prp_pkg::R3_W-1:0]    x3,
	output logic signed [prp_pkg::R3_W-1:0]    y3,
	output logic signed [prp_pkg::R2_W-1:0]    z2
);
	import prp_pkg::*;

	logic signed [15:0] ca, sa, cb, sb, cc, sc;
	logic [5:0] vld_s;

	logic signed [31:0]       pa_s1, pb_s1, pc_s1, pd_s1;
	logic signed [PT_W-1:0]   x_s1;
	logic signed [R1_W-1:0]   y1_s2, z1_s2;
	logic signed [PT_W-1:0]   x_s2;
	logic signed [34:0]       qa_s3, qb_s3, qc_s3, qd_s3;
	logic signed [R1_W-1:0]   y1_s3;
	logic signed [R2_W-1:0]   x2_s4, z2_s4;
	logic signed [R1_W-1:0]   y1_s4;
	logic signed [37:0]       ra_s5, rb_s5, rc_s5, rd_s5;
	logic signed [R2_W-1:0]   z2_s5;
	logic signed [R3_W-1:0]   x3_s6, y3_s6;
	logic signed [R2_W-1:0]   z2_s6;

	logic signed [32:0] sum_y1, sum_z1;
	logic signed [35:0] sum_x2, sum_z2;
	logic signed [38:0] sum_x3, sum_y3;

	assign ca = rot_x[31:16];
	assign sa = rot_x[15:0];
	assign cb = rot_y[31:16];
	assign sb = rot_y[15:0];
	assign cc = rot_z[31:16];
	assign sc = rot_z[15:0];

	// floor shift by 14 is just the upper bits of each sum
	assign sum_y1 = 33'(pa_s1) - 33'(pb_s1);
	assign sum_z1 = 33'(pc_s1) + 33'(pd_s1);
	assign sum_x2 = 36'(qa_s3) - 36'(qb_s3);
	assign sum_z2 = 36'(qc_s3) + 36'(qd_s3);
	assign sum_x3 = 39'(ra_s5) - 39'(rb_s5);
	assign sum_y3 = 39'(rc_s5) + 39'(rd_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[4:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1 <= ca * py;
			pb_s1 <= sa * pz;
			pc_s1 <= sa * py;
			pd_s1 <= ca * pz;
			x_s1  <= px;

			y1_s2 <= sum_y1[32:14];
			z1_s2 <= sum_z1[32:14];
			x_s2  <= x_s1;

			qa_s3 <= cb * x_s2;
			qb_s3 <= sb * z1_s2;
			qc_s3 <= sb * x_s2;
			qd_s3 <= cb * z1_s2;
			y1_s3 <= y1_s2;

			x2_s4 <= sum_x2[35:14];
			z2_s4 <= sum_z2[35:14];
			y1_s4 <= y1_s3;

			ra_s5 <= cc * x2_s4;
			rb_s5 <= sc * y1_s4;
			rc_s5 <= sc * x2_s4;
			rd_s5 <= cc * y1_s4;
			z2_s5 <= z2_s4;

			x3_s6 <= sum_x3[38:14];
			y3_s6 <= sum_y3[38:14];
			z2_s6 <= z2_s5;
		end
	end

	assign out_vld = vld_s[5];
	assign x3      = x3_s6;
	assign y3      = y3_s6;
	assign z2      = z2_s6;

endmodule

/* rtl/prp_div.sv */
module prp_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_vld,
	input  logic [prp_pkg::NUM_W-1:0]         num_x,
	input  logic [prp_pkg::NUM_W-1:0]         num_z,
	input  logic [prp_pkg::DEN_W-1:0]         den,
	input  prp_pkg::div_tag_t                 tag,
	output logic                              out_vld,
	output logic [prp_pkg::QB:0]              quo_x,
	output logic [prp_pkg::QB:0]              quo_z,
	output prp_pkg::div_tag_t                 tag_out
);
	import prp_pkg::*;

	logic [QB:0]        vld_s;
	logic [NUM_W-1:0]   rx_s  [QB+1];
	logic [NUM_W-1:0]   rz_s  [QB+1];
	logic [DEN_W-1:0]   den_s [QB+1];
	logic [QB-1:0]      qx_s  [QB+1];
	logic [QB-1:0]      qz_s  [QB+1];
	logic               ovx_s [QB+1];
	logic               ovz_s [QB+1];
	div_tag_t           tag_s [QB+1];
	logic [CMP_W-1:0]   den_top;

	assign den_top = CMP_W'(den) << QB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QB-1:0], in_vld};
		end
	end

	// quotients of 2^QB or more saturate the coordinate anyway: flag and clamp
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0]  <= num_x;
			rz_s[0]  <= num_z;
			den_s[0] <= den;
			qx_s[0]  <= '0;
			qz_s[0]  <= '0;
			ovx_s[0] <= CMP_W'(num_x) >= den_top;
			ovz_s[0] <= CMP_W'(num_z) >= den_top;
			tag_s[0] <= tag;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_bit
		localparam int B = QB - k;
		logic [CMP_W-1:0] dsh;
		logic             ge_x, ge_z;

		assign dsh  = CMP_W'(den_s[k-1]) << B;
		assign ge_x = CMP_W'(rx_s[k-1]) >= dsh;
		assign ge_z = CMP_W'(rz_s[k-1]) >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[k]    <= ge_x ? rx_s[k-1] - dsh[NUM_W-1:0] : rx_s[k-1];
				rz_s[k]    <= ge_z ? rz_s[k-1] - dsh[NUM_W-1:0] : rz_s[k-1];
				qx_s[k]    <= qx_s[k-1] | (QB'(ge_x) << B);
				qz_s[k]    <= qz_s[k-1] | (QB'(ge_z) << B);
				den_s[k]   <= den_s[k-1];
				ovx_s[k]   <= ovx_s[k-1];
				ovz_s[k]   <= ovz_s[k-1];
				tag_s[k]   <= tag_s[k-1];
			end
		end
	end

	assign out_vld = vld_s[QB];
	assign quo_x   = ovx_s[QB] ? {1'b1, QB'(0)} : {1'b0, qx_s[QB]};
	assign quo_z   = ovz_s[QB] ? {1'b1, QB'(0)} : {1'b0, qz_s[QB]};
	assign tag_out = tag_s[QB];

endmodule

/* rtl/point_rotate_project_unit.sv */
// channel | signals                                   | direction
// in      | in_valid, in_ready, point_x/y/z            | point item in
// out     | out_valid, out_ready, screen_x/y, flags    | screen item out
// cfg     | cfg_we, cfg_index, cfg_data                | register write
//
// One item per cycle unless out_ready stalls; from acceptance to out_valid:
// six rotation stages, three offset/scale stages, a 19-stage divider
// (range check plus one quotient bit per stage), and the output register.
// Reset clears all valid bits; registers return to their documented values.
// A stall on out_ready freezes the whole pipeline; in_ready drops with it.
module point_rotate_project_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [15:0]              point_x,
	input  logic signed [15:0]              point_y,
	input  logic signed [15:0]              point_z,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [15:0]              screen_x,
	output logic signed [15:0]              screen_y,
	output logic                            depth_zero,
	output logic                            clipped,
	input  logic                            cfg_we,
	input  logic [prp_pkg::IDX_W-1:0]       cfg_index,
	input  logic [prp_pkg::CFG_W-1:0]       cfg_data
);
	import prp_pkg::*;

	logic [CFG_W-1:0]         rot_x_q, rot_y_q, rot_z_q, center_q;
	logic signed [OFF_W-1:0]  off_x_q, off_d_q, off_z_q;
	logic [15:0]              zoom_q;

	logic adv;
	logic rot_vld;
	logic signed [R3_W-1:0] x3, y3;
	logic signed [R2_W-1:0] z2;

	logic vld_s7, vld_s8, vld_s9;
	logic signed [POS_W-1:0] x4_s7, d_s7, z4_s7;
	logic signed [PRD_W-1:0] nx_s8, nz_s8;
	logic [DEN_W-1:0]        dmag_s8;
	logic                    dneg_s8, dz_s8;
	logic [NUM_W-1:0]        numx_s9, numz_s9;
	logic [DEN_W-1:0]        den_s9;
	div_tag_t                tag_s9;

	logic [PRD_W-1:0]        ax, az;
	logic                    dv_vld;
	logic [QB:0]             qx, qz;
	div_tag_t                dv_tag;

	logic signed [QB+1:0]    sqx, sqz;
	logic signed [QB+2:0]    tx, ty;
	logic                    clx, cly;
	logic signed [15:0]      satx, saty;

	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q  <= 32'h4000_0000;
			rot_y_q  <= 32'h4000_0000;
			rot_z_q  <= 32'h4000_0000;
			off_x_q  <= 24'sd1;
			off_d_q  <= 24'sd800;
			off_z_q  <= -24'sd300;
			zoom_q   <= 16'd8000;
			center_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROT_X:  rot_x_q  <= cfg_data;
				REG_ROT_Y:  rot_y_q  <= cfg_data;
				REG_ROT_Z:  rot_z_q  <= cfg_data;
				REG_OFF_X:  off_x_q  <= cfg_data[OFF_W-1:0];
				REG_OFF_D:  off_d_q  <= cfg_data[OFF_W-1:0];
				REG_OFF_Z:  off_z_q  <= cfg_data[OFF_W-1:0];
				REG_ZOOM:   zoom_q   <= cfg_data[15:0];
				REG_CENTER: center_q <= cfg_data;
				default: ;
			endcase
		end
	end

	prp_rotate u_rotate (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (in_valid),
		.px      (point_x),
		.py      (point_y),
		.pz      (point_z),
		.rot_x   (rot_x_q),
		.rot_y   (rot_y_q),
		.rot_z   (rot_z_q),
		.out_vld (rot_vld),
		.x3      (x3),
		.y3      (y3),
		.z2      (z2)
	);

	assign ax = nx_s8[PRD_W-1] ? PRD_W'(-nx_s8) : PRD_W'(nx_s8);
	assign az = nz_s8[PRD_W-1] ? PRD_W'(-nz_s8) : PRD_W'(nz_s8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= rot_vld;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x4_s7 <= POS_W'(x3) + POS_W'(off_x_q);
			d_s7  <= POS_W'(y3) + POS_W'(off_d_q);
			z4_s7 <= POS_W'(z2) + POS_W'(off_z_q);

			nx_s8   <= x4_s7 * $signed({1'b0, zoom_q});
			nz_s8   <= z4_s7 * $signed({1'b0, zoom_q});
			dmag_s8 <= d_s7[POS_W-1] ? DEN_W'(-d_s7) : DEN_W'(d_s7);
			dneg_s8 <= d_s7[POS_W-1];
			dz_s8   <= d_s7 == '0;

			// dividing by 16*|d| equals dropping four bits, then dividing by |d|
			numx_s9      <= ax[PRD_W-1:4];
			numz_s9      <= az[PRD_W-1:4];
			den_s9       <= dmag_s8;
			tag_s9.neg_x <= nx_s8[PRD_W-1] ^ dneg_s8;
			tag_s9.neg_z <= nz_s8[PRD_W-1] ^ dneg_s8;
			tag_s9.dz    <= dz_s8;
		end
	end

	prp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (vld_s9),
		.num_x   (numx_s9),
		.num_z   (numz_s9),
		.den     (den_s9),
		.tag     (tag_s9),
		.out_vld (dv_vld),
		.quo_x   (qx),
		.quo_z   (qz),
		.tag_out (dv_tag)
	);

	assign sqx = dv_tag.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
	assign sqz = dv_tag.neg_z ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
	assign tx  = $signed({5'b0, center_q[31:16]}) - (QB+3)'(sqx);
	assign ty  = $signed({5'b0, center_q[15:0]}) + (QB+3)'(sqz);

	always_comb begin
		clx  = 1'b0;
		cly  = 1'b0;
		satx = tx[15:0];
		saty = ty[15:0];
		if (tx > 21'sd32767) begin
			satx = 16'sh7fff;
			clx  = 1'b1;
		end else if (tx < -21'sd32768) begin
			satx = 16'sh8000;
			clx  = 1'b1;
		end
		if (ty > 21'sd32767) begin
			saty = 16'sh7fff;
			cly  = 1'b1;
		end else if (ty < -21'sd32768) begin
			saty = 16'sh8000;
			cly  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			screen_x   <= dv_tag.dz ? '0 : satx;
			screen_y   <= dv_tag.dz ? '0 : saty;
			depth_zero <= dv_tag.dz;
			clipped    <= !dv_tag.dz && (clx || cly);
		end
	end

endmodule

/* rtl/prp_checker.sv */
module prp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] screen_x,
	input logic signed [15:0] screen_y,
	input logic               depth_zero,
	input logic               clipped
);

	// hold a stalled item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(screen_x) && $stable(screen_y))
		else $error("stalled item changed");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && depth_zero |-> screen_x == 16'sd0 && screen_y == 16'sd0 && !clipped)
		else $error("zero depth item not cleared");

	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |->
			screen_x == 16'sh7fff || screen_x == 16'sh8000 ||
			screen_y == 16'sh7fff || screen_y == 16'sh8000)
		else $error("clip flag without a limit value");

endmodule

bind point_rotate_project_unit prp_checker u_prp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.screen_x   (screen_x),
	.screen_y   (screen_y),
	.depth_zero (depth_zero),
	.clipped    (clipped)
);
